>>> src/tdi_pkg.sv
package tdi_pkg;

    localparam int COORD_W           = 9;
    localparam int DIST_W            = 8;
    // Sum of two squared 9-bit magnitudes fits in 19 bits.
    localparam int SUM_W             = 2 * COORD_W + 1;
    // A sum at or above 2**16 means a distance above 255.
    localparam int SAT_BIT           = 2 * DIST_W;
    localparam int RADICAND_BITS_DEF = 20;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y = 2'd1;

    localparam logic [COORD_W-1:0] CENTRE_X_RST = 9'd240;
    localparam logic [COORD_W-1:0] CENTRE_Y_RST = 9'd136;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQUARE,
        S_LOAD,
        S_ROOT
    } t_state;

endpackage

>>> src/tdi_isqrt.sv
module tdi_isqrt #(
    parameter int RAD_W = tdi_pkg::RADICAND_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [RAD_W-1:0]         i_radicand,
    output logic                     o_done,
    output logic [(RAD_W+1)/2-1:0]   o_root
);

    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int PAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 1;
    localparam int TRY_W  = ROOT_W + 3;
    localparam int CNT_W  = $clog2(ROOT_W);

    logic [PAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_active;
    logic              r_done;

    logic [TRY_W-1:0]  w_rem_sh;
    logic [TRY_W-1:0]  w_trial;
    logic [TRY_W-1:0]  w_diff;
    logic              w_ge;

    // One result bit per cycle: bring down the next pair of radicand bits and
    // try subtracting four times the partial root plus one.
    always_comb begin
        w_rem_sh = {r_rem, r_rad[PAD_W-1 -: 2]};
        w_trial  = {1'b0, r_root, 2'b01};
        w_ge     = (w_rem_sh >= w_trial);
        w_diff   = w_rem_sh - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
            end else if (r_active) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= PAD_W'(i_radicand);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_active) begin
            r_rad  <= {r_rad[PAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_rem_sh[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> src/touch_distance_isqrt.sv
// Distance of a touch point from a programmable circle centre.
//
// A request is taken on a rising edge where start is high and busy is low;
// i_touch_x and i_touch_y are sampled at that edge. The block forms the
// magnitudes of the offsets from the centre, squares and adds them with a
// shift-and-add multiplier that consumes one multiplier bit per cycle, then
// takes the floor of the square root two radicand bits (one root bit) per
// cycle. Roots above 255, and any sum of 2**16 or more, give distance 255
// with o_saturated set.
//
// o_done is high for one cycle when a result is ready. busy
// falls in that same cycle, so the next request can be taken at the edge that
// ends it. A request passes through the nine-step squarer and then the
// ten-step root unit.
// The receiver cannot stall; the result is shown for that single cycle.
//
// The centre registers are written through i_cfg_valid/i_cfg_index/
// i_cfg_data; o_cfg_ready is always high and unknown indexes are dropped.
// Reset sets the centre to (240, 136) and leaves the block idle.
module touch_distance_isqrt #(
    parameter int RADICAND_BITS = tdi_pkg::RADICAND_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tdi_pkg::COORD_W-1:0]    i_touch_x,
    input  logic [tdi_pkg::COORD_W-1:0]    i_touch_y,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tdi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tdi_pkg::COORD_W-1:0]    i_cfg_data,
    output logic                           o_done,
    output logic [tdi_pkg::DIST_W-1:0]     o_distance,
    output logic                           o_saturated
);

    localparam int COORD_W  = tdi_pkg::COORD_W;
    localparam int SUM_W    = tdi_pkg::SUM_W;
    localparam int DIST_W   = tdi_pkg::DIST_W;
    localparam int ROOT_W   = (RADICAND_BITS + 1) / 2;
    localparam int EXT_W    = ROOT_W + DIST_W;
    localparam int WIDE_W   = (RADICAND_BITS > SUM_W) ? RADICAND_BITS : SUM_W;
    localparam int SQ_CNT_W = $clog2(COORD_W);
    localparam logic [WIDE_W-1:0] LIMIT = WIDE_W'((64'd1 << RADICAND_BITS) - 64'd1);

    tdi_pkg::t_state r_state;
    tdi_pkg::t_state n_state;

    logic [COORD_W-1:0]  r_centre_x;
    logic [COORD_W-1:0]  r_centre_y;
    logic [SUM_W-1:0]    r_mcand_x;
    logic [SUM_W-1:0]    r_mcand_y;
    logic [COORD_W-1:0]  r_mplier_x;
    logic [COORD_W-1:0]  r_mplier_y;
    logic [SUM_W-1:0]    r_acc;
    logic [SQ_CNT_W-1:0] r_sq_cnt;
    logic                r_sat;
    logic                r_out_valid;
    logic [DIST_W-1:0]   r_distance;
    logic                r_saturated;

    logic                w_accept;
    logic                w_root_start;
    logic                w_root_done;
    logic [ROOT_W-1:0]   w_root;
    logic [EXT_W-1:0]    w_root_ext;
    logic [COORD_W:0]    w_dx;
    logic [COORD_W:0]    w_dy;
    logic [COORD_W:0]    w_dx_neg;
    logic [COORD_W:0]    w_dy_neg;
    logic [COORD_W-1:0]  w_adx;
    logic [COORD_W-1:0]  w_ady;
    logic [SUM_W-1:0]    w_part_x;
    logic [SUM_W-1:0]    w_part_y;
    logic [WIDE_W-1:0]   w_sum_wide;
    logic [RADICAND_BITS-1:0] w_radicand;
    logic                w_clip;

    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_x <= tdi_pkg::CENTRE_X_RST;
            r_centre_y <= tdi_pkg::CENTRE_Y_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tdi_pkg::CFG_CENTRE_X: r_centre_x <= i_cfg_data;
                tdi_pkg::CFG_CENTRE_Y: r_centre_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        busy         = 1'b1;
        w_root_start = 1'b0;
        unique case (r_state)
            tdi_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_state = tdi_pkg::S_SQUARE;
                end
            end
            tdi_pkg::S_SQUARE: begin
                if (r_sq_cnt == SQ_CNT_W'(COORD_W - 1)) begin
                    n_state = tdi_pkg::S_LOAD;
                end
            end
            tdi_pkg::S_LOAD: begin
                w_root_start = 1'b1;
                n_state      = tdi_pkg::S_ROOT;
            end
            tdi_pkg::S_ROOT: begin
                if (w_root_done) begin
                    n_state = tdi_pkg::S_IDLE;
                end
            end
            default: n_state = tdi_pkg::S_IDLE;
        endcase
    end

    // Offset magnitudes; the negation of -511 still fits the 9-bit magnitude.
    always_comb begin
        w_dx     = {1'b0, i_touch_x} - {1'b0, r_centre_x};
        w_dy     = {1'b0, i_touch_y} - {1'b0, r_centre_y};
        w_dx_neg = -w_dx;
        w_dy_neg = -w_dy;
        w_adx    = w_dx[COORD_W] ? w_dx_neg[COORD_W-1:0] : w_dx[COORD_W-1:0];
        w_ady    = w_dy[COORD_W] ? w_dy_neg[COORD_W-1:0] : w_dy[COORD_W-1:0];
        w_part_x = r_mplier_x[0] ? r_mcand_x : '0;
        w_part_y = r_mplier_y[0] ? r_mcand_y : '0;
    end

    // Both squares share one accumulator, one multiplier bit of each per cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mcand_x  <= SUM_W'(w_adx);
            r_mcand_y  <= SUM_W'(w_ady);
            r_mplier_x <= w_adx;
            r_mplier_y <= w_ady;
            r_acc      <= '0;
            r_sq_cnt   <= '0;
        end else if (r_state == tdi_pkg::S_SQUARE) begin
            r_mcand_x  <= {r_mcand_x[SUM_W-2:0], 1'b0};
            r_mcand_y  <= {r_mcand_y[SUM_W-2:0], 1'b0};
            r_mplier_x <= {1'b0, r_mplier_x[COORD_W-1:1]};
            r_mplier_y <= {1'b0, r_mplier_y[COORD_W-1:1]};
            r_acc      <= r_acc + w_part_x + w_part_y;
            r_sq_cnt   <= r_sq_cnt + SQ_CNT_W'(1);
        end
    end

    always_comb begin
        w_sum_wide = WIDE_W'(r_acc);
        w_radicand = (w_sum_wide > LIMIT) ? LIMIT[RADICAND_BITS-1:0]
                                          : w_sum_wide[RADICAND_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_root_start) begin
            r_sat <= |r_acc[SUM_W-1:tdi_pkg::SAT_BIT];
        end
    end

    tdi_isqrt #(
        .RAD_W      (RADICAND_BITS)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_root_start),
        .i_radicand (w_radicand),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    always_comb begin
        w_root_ext = EXT_W'(w_root);
        w_clip     = r_sat || (|w_root_ext[EXT_W-1:DIST_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_root_done && (r_state == tdi_pkg::S_ROOT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_root_done) begin
            r_distance  <= w_clip ? {DIST_W{1'b1}} : w_root_ext[DIST_W-1:0];
            r_saturated <= r_sat;
        end
    end

    assign o_done      = r_out_valid;
    assign o_distance  = r_distance;
    assign o_saturated = r_saturated;

    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_saturated |-> o_distance == {DIST_W{1'b1}})
        else $error("saturated result without full-scale distance");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy && !o_done)
        else $error("block not busy after taking a request");

    a_root_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_done |-> r_state == tdi_pkg::S_ROOT)
        else $error("root unit finished outside the root phase");

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(w_root_done))
        else $error("result strobe without a finished root");

endmodule

>>> bench/touch_distance_isqrt_tb.sv
module touch_distance_isqrt_tb;

    localparam int COORD_W       = tdi_pkg::COORD_W;
    localparam int DIST_W        = tdi_pkg::DIST_W;
    localparam int CFG_IDX_W     = tdi_pkg::CFG_IDX_W;
    localparam int SAT_BIT       = tdi_pkg::SAT_BIT;
    localparam int RAD_BITS      = tdi_pkg::RADICAND_BITS_DEF;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RUN_LIMIT     = 1_000_000;

    // Indexes that the block has no register for; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_touch;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIST_W-1:0]  distance;
        logic               saturated;
    } t_distance;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic [COORD_W-1:0]    i_touch_x   = '0;
    logic [COORD_W-1:0]    i_touch_y   = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [COORD_W-1:0]    i_cfg_data  = '0;
    logic                  o_done;
    logic [DIST_W-1:0]     o_distance;
    logic                  o_saturated;

    // Testbench copy of the centre registers.
    logic [COORD_W-1:0]    centre_x = tdi_pkg::CENTRE_X_RST;
    logic [COORD_W-1:0]    centre_y = tdi_pkg::CENTRE_Y_RST;

    t_touch                touch_q[$];
    t_distance             distance_q[$];
    t_touch                cur_touch;
    int unsigned           gap_left   = 0;
    bit                    no_gaps    = 1'b0;
    int unsigned           n_sent     = 0;
    int unsigned           n_checked  = 0;
    int unsigned           n_clipped  = 0;
    int unsigned           n_settings = 1;
    int unsigned           n_errors   = 0;

    touch_distance_isqrt #(
        .RADICAND_BITS(RAD_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_touch_x   (i_touch_x),
        .i_touch_y   (i_touch_y),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_distance  (o_distance),
        .o_saturated (o_saturated)
    );

    always #1 i_clk = ~i_clk;

    // Floor square root, two radicand bits per step.
    function automatic logic [31:0] int_sqrt(input longint unsigned value);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned one;
        rem = value;
        res = 0;
        one = 64'd1 << ((RAD_BITS - 1) & ~1);
        while (one > rem)
            one >>= 2;
        while (one != 0) begin
            if (rem >= res + one) begin
                rem -= res + one;
                res = (res >> 1) + one;
            end else begin
                res >>= 1;
            end
            one >>= 2;
        end
        return res[31:0];
    endfunction

    function automatic t_distance calc_distance(input t_touch t, input logic [COORD_W-1:0] cx,
                                                input logic [COORD_W-1:0] cy);
        int              dx;
        int              dy;
        longint unsigned sum;
        longint unsigned limit;
        longint unsigned rad;
        logic [31:0]     root;
        t_distance       d;
        dx    = int'(t.x) - int'(cx);
        dy    = int'(t.y) - int'(cy);
        sum   = 64'(dx * dx) + 64'(dy * dy);
        limit = (64'd1 << RAD_BITS) - 64'd1;
        rad   = (sum > limit) ? limit : sum;
        root  = int_sqrt(rad);
        d.x         = t.x;
        d.y         = t.y;
        d.saturated = (sum >= (64'd1 << SAT_BIT));
        d.distance  = (d.saturated || root > 32'd255) ? '1 : root[DIST_W-1:0];
        return d;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 96)
            return $urandom_range(5, 25);
        return $urandom_range(26, 80);
    endfunction

    // Mix of wild codes, on-screen points, points close to the centre and
    // points on the radius where clipping starts.
    function automatic t_touch make_touch(input logic [COORD_W-1:0] cx,
                                          input logic [COORD_W-1:0] cy);
        int unsigned r;
        int          a;
        int          b;
        int          tmp;
        t_touch      t;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            t.x = COORD_W'($urandom);
            t.y = COORD_W'($urandom);
        end else if (r < 60) begin
            t.x = COORD_W'($urandom_range(0, 479));
            t.y = COORD_W'($urandom_range(0, 271));
        end else if (r < 80) begin
            t.x = COORD_W'(int'(cx) + $urandom_range(0, 32) - 16);
            t.y = COORD_W'(int'(cy) + $urandom_range(0, 32) - 16);
        end else begin
            a = $urandom_range(0, 256);
            b = int'(int_sqrt(64'(65536 - a * a))) + $urandom_range(0, 2) - 1;
            if (b < 0)
                b = 0;
            if ($urandom_range(0, 1)) begin
                tmp = a;
                a   = b;
                b   = tmp;
            end
            if ($urandom_range(0, 1))
                a = -a;
            if ($urandom_range(0, 1))
                b = -b;
            t.x = COORD_W'(int'(cx) + a);
            t.y = COORD_W'(int'(cy) + b);
        end
        return t;
    endfunction

    task automatic push_touch(input int x, input int y);
        touch_q.push_back('{x: COORD_W'(x), y: COORD_W'(y)});
    endtask

    // Polls on the falling edge so that the clocked blocks have settled.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (touch_q.size() != 0 || start || distance_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready)
                break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_IDX_W'($urandom);
        i_cfg_data  <= COORD_W'($urandom);
        case (idx)
            tdi_pkg::CFG_CENTRE_X: centre_x = value;
            tdi_pkg::CFG_CENTRE_Y: centre_y = value;
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                             input int count, input bit gaps_off);
        wait_idle();
        write_reg(tdi_pkg::CFG_CENTRE_X, cx);
        write_reg(tdi_pkg::CFG_CENTRE_Y, cy);
        n_settings++;
        @(negedge i_clk);
        no_gaps = gaps_off;
        for (int i = 0; i < count; i++)
            touch_q.push_back(make_touch(centre_x, centre_y));
    endtask

    // Driver: presents one request at a time and records its expected result
    // at the edge where the block takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                distance_q.push_back(calc_distance(cur_touch, centre_x, centre_y));
                n_sent++;
            end
            if (start && busy) begin
                // Held until the block is free.
            end else if (gap_left > 0) begin
                gap_left--;
                start     <= 1'b0;
                i_touch_x <= COORD_W'($urandom);
                i_touch_y <= COORD_W'($urandom);
            end else if (touch_q.size() > 0) begin
                cur_touch = touch_q.pop_front();
                i_touch_x <= cur_touch.x;
                i_touch_y <= cur_touch.y;
                start     <= 1'b1;
                gap_left  = no_gaps ? 0 : pick_gap();
            end else begin
                start     <= 1'b0;
                i_touch_x <= COORD_W'($urandom);
                i_touch_y <= COORD_W'($urandom);
            end
        end
    end

    always @(posedge i_clk) begin
        t_distance want;
        if (i_rst_n && o_done) begin
            if (distance_q.size() == 0) begin
                $display("%0t: result with no request outstanding: distance %0d saturated %0b",
                         $time, o_distance, o_saturated);
                n_errors++;
            end else begin
                want = distance_q.pop_front();
                if (o_distance !== want.distance) begin
                    $display("%0t: touch (%0d,%0d) distance expected %0d, got %0d",
                             $time, want.x, want.y, want.distance, o_distance);
                    n_errors++;
                end
                if (o_saturated !== want.saturated) begin
                    $display("%0t: touch (%0d,%0d) saturated expected %0b, got %0b",
                             $time, want.x, want.y, want.saturated, o_saturated);
                    n_errors++;
                end
                n_checked++;
                if (want.saturated)
                    n_clipped++;
            end
        end
    end

    initial begin
        int waited;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset centre: zero distance, the corners, the clipping radius and
        // small exact and inexact roots.
        push_touch(240, 136);
        push_touch(0, 0);
        push_touch(511, 511);
        push_touch(479, 271);
        push_touch(0, 511);
        push_touch(511, 0);
        push_touch(495, 136);
        push_touch(496, 136);
        push_touch(240, 391);
        push_touch(243, 140);
        push_touch(243, 139);
        push_touch(420, 316);

        // Centre at the origin: largest sum of squares and both sides of 255.
        run_phase(0, 0, 0, 1'b0);
        push_touch(511, 511);
        push_touch(255, 0);
        push_touch(0, 256);
        push_touch(181, 181);
        push_touch(181, 182);
        push_touch(1, 1);

        // Centre at the far code corner.
        run_phase(511, 511, 0, 1'b0);
        push_touch(0, 0);
        push_touch(511, 511);
        push_touch(256, 511);

        run_phase(0, 0, 70, 1'b0);
        run_phase(511, 511, 60, 1'b0);
        run_phase(479, 271, 60, 1'b1);

        // Writes to spare indexes must leave the centre alone.
        wait_idle();
        write_reg(CFG_SPARE_2, COORD_W'($urandom));
        write_reg(CFG_SPARE_3, COORD_W'($urandom));
        write_reg(CFG_SPARE_2, '1);
        write_reg(CFG_SPARE_3, '0);
        @(negedge i_clk);
        no_gaps = 1'b0;
        for (int i = 0; i < 20; i++)
            touch_q.push_back(make_touch(centre_x, centre_y));

        run_phase(COORD_W'($urandom_range(0, 479)), COORD_W'($urandom_range(0, 271)), 60,
                  1'b0);
        run_phase(tdi_pkg::CENTRE_X_RST, tdi_pkg::CENTRE_Y_RST, 60,
                  $urandom_range(0, 3) == 0);
        run_phase(COORD_W'($urandom), COORD_W'($urandom), 70, 1'b0);

        while (touch_q.size() != 0)
            @(negedge i_clk);
        waited = 0;
        while (distance_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (distance_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, distance_q.size());
            n_errors += distance_q.size();
        end

        $display("Covered %0d touch requests over %0d centre settings, %0d results checked.",
                 n_sent, n_settings, n_checked);
        $display("Of those, %0d were clipped at the maximum distance; %0d errors seen.",
                 n_clipped, n_errors);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("%0t: run did not finish in time", $time);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
src/tdi_pkg.sv
src/tdi_isqrt.sv
src/touch_distance_isqrt.sv
bench/touch_distance_isqrt_tb.sv
